FILE: rtl/core/rslot_pkg.sv
package rslot_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int MAX_PAYLOAD_DEF = 64;

  // Request kinds carried on the input tuser.
  localparam logic [2:0] REQ_ENQUEUE = 3'd0;
  localparam logic [2:0] REQ_POLL    = 3'd1;
  localparam logic [2:0] REQ_ACK     = 3'd2;
  localparam logic [2:0] REQ_CANCEL  = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  // Result codes carried on the output tuser.
  localparam logic [3:0] RES_QUEUED     = 4'd0;
  localparam logic [3:0] RES_FULL       = 4'd1;
  localparam logic [3:0] RES_INVALID    = 4'd2;
  localparam logic [3:0] RES_SEND       = 4'd3;
  localparam logic [3:0] RES_EXHAUSTED  = 4'd4;
  localparam logic [3:0] RES_NONE_DUE   = 4'd5;
  localparam logic [3:0] RES_ACK_OK     = 4'd6;
  localparam logic [3:0] RES_ACK_REJECT = 4'd7;
  localparam logic [3:0] RES_NOT_FOUND  = 4'd8;
  localparam logic [3:0] RES_CANCELLED  = 4'd9;
  localparam logic [3:0] RES_CLEARED    = 4'd10;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_ATTEMPT_LIMIT = 1'b0;
  localparam logic REG_RETRY_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [7:0]  node;
    logic [7:0]  seq;
    logic [15:0] tag;
    logic [31:0] deadline;
    logic [7:0]  attempts;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

endpackage

FILE: rtl/core/rslot_ram.sv
module rslot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/retransmission_slot_table.sv
// Channel  Dir  Width  Contents
// s_*      in   80+3   request: tdata node/seq/length/tag/now/ack_ok, tuser request kind
// m_*      out  48+4   result: tdata node/seq/tag/attempts/pending, tuser result code
// APB      in   32     attempt limit at 0x0, retry_timeout at 0x4
//
// Each request scans the slot memory one slot per cycle, and a hit ends the
// scan early. Clear, unknown kinds and overlong enqueues skip the scan.
// The one read port of the slot memory and the one shared 32-bit adder
// (deadline compare during the scan, rearm in the decision step) set the rate.
// Reset empties the table at once. A stalled result stays in the output
// register; the next request is still taken, and its result then waits in the
// output state until the earlier transfer completes. s_tready is high only
// while the block is idle.
module retransmission_slot_table
  import rslot_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] node_id, [15:8] sequence_req, [23:16] payload_len,
  // [39:24] frame_tag, [71:40] now_ms, [72] ack_ok, [79:73] zero
  input  logic [79:0] s_tdata,
  // [2:0] req_type
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] out_node, [15:8] out_sequence, [31:16] out_tag,
  // [39:32] attempt_count, [43:40] pending_slots, [47:44] zero
  output logic [47:0] m_tdata,
  // [3:0] result_code
  output logic [3:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DONE = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic [7:0]  attempt_limit;
  logic [30:0] retry_timeout;

  logic [2:0]  req;
  logic [7:0]  r_node;
  logic [7:0]  r_seq;
  logic [15:0] r_tag;
  logic [31:0] r_now;
  logic        r_ok;
  logic        len_bad;

  logic            iss_busy;
  logic [IDXW-1:0] iss_idx;
  logic            chk_vld;
  logic [IDXW-1:0] chk_idx;
  logic            hit_found;
  logic [IDXW-1:0] hit_idx;
  slot_rec_t       hit_rec;
  logic            free_found;
  logic [IDXW-1:0] free_idx;

  logic [SLOTS-1:0] valid;
  logic [CNTW-1:0]  pending;

  logic [3:0]  res_code;
  logic [7:0]  res_node;
  logic [7:0]  res_seq;
  logic [15:0] res_tag;
  logic [7:0]  res_att;

  slot_rec_t       rd_rec;
  slot_rec_t       wr_rec;
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;

  logic [31:0] alu_b;
  logic        alu_cin;
  logic [31:0] alu_sum;

  logic       chk_valid;
  logic       chk_match;
  logic       chk_due;
  logic       chk_hit;
  logic       att_spent;
  logic       poll_hit;
  logic       cfg_wr;
  logic [6:0] pend_ext;
  logic [3:0] pend_out;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit <= 8'd3;
      retry_timeout <= 31'd1000;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ATTEMPT_LIMIT: begin
          attempt_limit <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
        end
        REG_RETRY_TIMEOUT: begin
          retry_timeout <= pwdata[30:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ATTEMPT_LIMIT: prdata = {24'd0, attempt_limit};
      REG_RETRY_TIMEOUT: prdata = {1'b0, retry_timeout};
      default:           prdata = 32'd0;
    endcase
  end

  // Slot memory: read at the scan index, written in the decision step.
  rslot_ram #(
    .WIDTH(REC_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_addr (iss_idx),
    .rd_data (rd_rec)
  );

  // Shared adder: now - deadline while scanning, now + timeout when rearming.
  always_comb begin
    if (state == ST_DONE) begin
      alu_b   = {1'b0, retry_timeout};
      alu_cin = 1'b0;
    end else begin
      alu_b   = ~rd_rec.deadline;
      alu_cin = 1'b1;
    end
  end
  assign alu_sum = r_now + alu_b + 32'(alu_cin);

  assign chk_valid = valid[chk_idx];
  assign chk_match = chk_valid && (rd_rec.node == r_node) && (rd_rec.seq == r_seq);
  assign chk_due   = chk_valid && !alu_sum[31];
  assign chk_hit   = (req == REQ_POLL) ? chk_due : chk_match;
  assign att_spent = hit_rec.attempts >= attempt_limit;
  assign poll_hit  = (req == REQ_POLL) && hit_found;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx;
    wr_rec  = hit_rec;
    if (state == ST_DONE) begin
      if (req == REQ_ENQUEUE) begin
        wr_en           = !len_bad && !hit_found && free_found;
        wr_addr         = free_idx;
        wr_rec.node     = r_node;
        wr_rec.seq      = r_seq;
        wr_rec.tag      = r_tag;
        wr_rec.deadline = r_now;
        wr_rec.attempts = 8'd0;
      end else if (req == REQ_POLL) begin
        wr_en           = hit_found && !att_spent;
        wr_rec.deadline = alu_sum;
        wr_rec.attempts = hit_rec.attempts + 8'd1;
      end
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      pending    <= '0;
      iss_busy   <= 1'b0;
      chk_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // In the output state the valid flag is handled below.
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req        <= s_tuser;
            r_node     <= s_tdata[7:0];
            r_seq      <= s_tdata[15:8];
            r_tag      <= s_tdata[39:24];
            r_now      <= s_tdata[71:40];
            r_ok       <= s_tdata[72];
            len_bad    <= s_tdata[23:16] > 8'(MAX_PAYLOAD);
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            iss_idx    <= '0;
            chk_vld    <= 1'b0;
            if ((s_tuser == REQ_ENQUEUE && s_tdata[23:16] <= 8'(MAX_PAYLOAD)) ||
                s_tuser == REQ_POLL || s_tuser == REQ_ACK || s_tuser == REQ_CANCEL) begin
              iss_busy <= 1'b1;
              state    <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (iss_busy) begin
            iss_idx <= iss_idx + IDXW'(1);
            if (iss_idx == LAST_IDX) begin
              iss_busy <= 1'b0;
            end
          end
          chk_vld <= iss_busy;
          chk_idx <= iss_idx;
          if (chk_vld) begin
            if (chk_hit) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_idx;
              hit_rec   <= rd_rec;
              state     <= ST_DONE;
            end else begin
              if (!chk_valid && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= chk_idx;
              end
              if (chk_idx == LAST_IDX) begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          res_node <= poll_hit ? hit_rec.node : 8'd0;
          res_seq  <= poll_hit ? hit_rec.seq : 8'd0;
          res_tag  <= poll_hit ? hit_rec.tag : 16'd0;
          res_att  <= !poll_hit ? 8'd0 :
                      (att_spent ? hit_rec.attempts : hit_rec.attempts + 8'd1);
          case (req)
            REQ_ENQUEUE: begin
              if (len_bad || hit_found) begin
                res_code <= RES_INVALID;
              end else if (free_found) begin
                valid[free_idx] <= 1'b1;
                pending         <= pending + CNTW'(1);
                res_code        <= RES_QUEUED;
              end else begin
                res_code <= RES_FULL;
              end
            end
            REQ_POLL: begin
              if (!hit_found) begin
                res_code <= RES_NONE_DUE;
              end else if (att_spent) begin
                valid[hit_idx] <= 1'b0;
                pending        <= pending - CNTW'(1);
                res_code       <= RES_EXHAUSTED;
              end else begin
                res_code <= RES_SEND;
              end
            end
            REQ_ACK, REQ_CANCEL: begin
              if (!hit_found) begin
                res_code <= RES_NOT_FOUND;
              end else begin
                valid[hit_idx] <= 1'b0;
                pending        <= pending - CNTW'(1);
                if (req == REQ_CANCEL) begin
                  res_code <= RES_CANCELLED;
                end else begin
                  res_code <= r_ok ? RES_ACK_OK : RES_ACK_REJECT;
                end
              end
            end
            REQ_CLEAR: begin
              valid    <= '0;
              pending  <= '0;
              res_code <= RES_CLEARED;
            end
            default: begin
              res_code <= RES_INVALID;
            end
          endcase
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_code;
            m_tdata  <= {4'd0, pend_out, res_att, res_tag, res_seq, res_node};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The count saturates at 15 for tables larger than the field can show.
  assign pend_ext = 7'(pending);
  assign pend_out = (pend_ext > 7'd15) ? 4'd15 : pend_ext[3:0];

endmodule

FILE: rtl/core/rslot_chk.sv
module rslot_chk
  import rslot_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [3:0]  m_tuser
);

  localparam logic [3:0] PEND_MAX = 4'((SLOTS > 15) ? 15 : SLOTS);

  // A request keeps the block busy after its transfer, so s_tready drops.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted on consecutive cycles");

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[43:40] <= PEND_MAX)
    else $error("pending count beyond the table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == RES_CLEARED |-> m_tdata[43:40] == 4'd0)
    else $error("table not empty after clear");

  // Frame fields are only reported for a send or an exhausted frame.
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != RES_SEND && m_tuser != RES_EXHAUSTED
      |-> m_tdata[39:0] == 40'd0)
    else $error("frame fields set on a result without a frame");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind retransmission_slot_table rslot_chk #(.SLOTS(SLOTS)) u_rslot_chk (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rslot_pkg::*;

  localparam int SLOTS         = SLOTS_DEF;
  localparam int MAX_PAYLOAD   = MAX_PAYLOAD_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;

  // Request kinds the block does not know; they must come back as invalid.
  localparam logic [2:0] REQ_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] REQ_LAST_UNKNOWN  = 3'd7;

  typedef struct packed {
    logic [3:0]  code;
    logic [7:0]  node;
    logic [7:0]  seq;
    logic [15:0] tag;
    logic [7:0]  attempts;
    logic [3:0]  pending;
  } response_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [7:0] node_id, [15:8] sequence_req, [23:16] payload_len,
  // [39:24] frame_tag, [71:40] now_ms, [72] ack_ok, [79:73] zero
  logic [79:0] s_tdata  = '0;
  // [2:0] req_type
  logic [2:0]  s_tuser  = REQ_ENQUEUE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] out_node, [15:8] out_sequence, [31:16] out_tag,
  // [39:32] attempt_count, [43:40] pending_slots, [47:44] zero
  logic [47:0] m_tdata;
  // [3:0] result_code
  logic [3:0]  m_tuser;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted contents of the slot table and its registers.
  logic        tbl_valid    [SLOTS];
  logic [7:0]  tbl_node     [SLOTS];
  logic [7:0]  tbl_seq      [SLOTS];
  logic [15:0] tbl_tag      [SLOTS];
  logic [31:0] tbl_deadline [SLOTS];
  logic [7:0]  tbl_attempts [SLOTS];
  logic [7:0]  cfg_attempt_limit = 8'd3;
  logic [30:0] cfg_retry_timeout = 31'd1000;

  response_t expected_responses[$];

  logic [31:0] clock_ms = '0;
  bit          calm = 1'b0;
  bit          sink_hold = 1'b0;
  bit          sink_holding = 1'b0;
  int          failures = 0;
  int          requests_accepted = 0;
  int          responses_checked = 0;
  int          exhausted_seen = 0;
  int          full_seen = 0;
  int          register_writes = 0;
  int          cycle_count = 0;

  retransmission_slot_table #(
    .SLOTS      (SLOTS),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int find_slot(input logic [7:0] node, input logic [7:0] seq);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_node[i] == node && tbl_seq[i] == seq) return i;
    end
    return -1;
  endfunction

  task automatic predict_request(input logic [2:0] kind, input logic [79:0] data);
    logic [7:0]  node;
    logic [7:0]  seq;
    logic [7:0]  len;
    logic [15:0] tag;
    logic [31:0] now;
    logic [31:0] age;
    logic        ok;
    int          hit;
    int          pick;
    int          count;
    response_t   r;
    node = data[7:0];
    seq  = data[15:8];
    len  = data[23:16];
    tag  = data[39:24];
    now  = data[71:40];
    ok   = data[72];
    r    = '0;
    hit  = find_slot(node, seq);
    case (kind)
      REQ_ENQUEUE: begin
        // The duplicate check wins over the full check.
        if (len > MAX_PAYLOAD || hit >= 0) begin
          r.code = RES_INVALID;
        end else begin
          pick = -1;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) pick = i;
          end
          if (pick < 0) begin
            r.code = RES_FULL;
          end else begin
            tbl_valid[pick]    = 1'b1;
            tbl_node[pick]     = node;
            tbl_seq[pick]      = seq;
            tbl_tag[pick]      = tag;
            tbl_deadline[pick] = now;
            tbl_attempts[pick] = 8'd0;
            r.code = RES_QUEUED;
          end
        end
      end
      REQ_POLL: begin
        r.code = RES_NONE_DUE;
        pick = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          age = now - tbl_deadline[i];
          if (tbl_valid[i] && !age[31]) pick = i;
        end
        if (pick >= 0) begin
          r.node = tbl_node[pick];
          r.seq  = tbl_seq[pick];
          r.tag  = tbl_tag[pick];
          if (tbl_attempts[pick] >= cfg_attempt_limit) begin
            r.attempts = tbl_attempts[pick];
            tbl_valid[pick] = 1'b0;
            r.code = RES_EXHAUSTED;
          end else begin
            tbl_attempts[pick] = tbl_attempts[pick] + 8'd1;
            tbl_deadline[pick] = now + {1'b0, cfg_retry_timeout};
            r.attempts = tbl_attempts[pick];
            r.code = RES_SEND;
          end
        end
      end
      REQ_ACK: begin
        if (hit < 0) begin
          r.code = RES_NOT_FOUND;
        end else begin
          tbl_valid[hit] = 1'b0;
          r.code = ok ? RES_ACK_OK : RES_ACK_REJECT;
        end
      end
      REQ_CANCEL: begin
        if (hit < 0) begin
          r.code = RES_NOT_FOUND;
        end else begin
          tbl_valid[hit] = 1'b0;
          r.code = RES_CANCELLED;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        r.code = RES_CLEARED;
      end
      default: begin
        r.code = RES_INVALID;
      end
    endcase
    count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) count++;
    end
    r.pending = (count > 15) ? 4'd15 : count[3:0];
    expected_responses.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      requests_accepted++;
      predict_request(s_tuser, s_tdata);
    end
  end

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : check_response
    response_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: response with no request outstanding, expected none, actual code %0d",
                 $time, m_tuser);
        failures++;
      end else begin
        want = expected_responses.pop_front();
        responses_checked++;
        if (want.code == RES_EXHAUSTED) exhausted_seen++;
        if (want.code == RES_FULL) full_seen++;
        compare_field("result_code", 32'(want.code), 32'(m_tuser));
        compare_field("out_node", 32'(want.node), 32'(m_tdata[7:0]));
        compare_field("out_sequence", 32'(want.seq), 32'(m_tdata[15:8]));
        compare_field("out_tag", 32'(want.tag), 32'(m_tdata[31:16]));
        compare_field("attempt_count", 32'(want.attempts), 32'(m_tdata[39:32]));
        compare_field("pending_slots", 32'(want.pending), 32'(m_tdata[43:40]));
      end
    end
  end

  // Result side: random stalls, plus one long hold on request.
  initial begin : result_sink
    int span;
    @(posedge clk);
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        sink_holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_holding = 1'b0;
        sink_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        span = $urandom_range(1, 18);
        repeat (span) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        span = $urandom_range(1, 24);
        repeat (span) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [7:0] node,
                              input logic [7:0] seq, input logic [7:0] len,
                              input logic [15:0] tag, input logic [31:0] now,
                              input logic ok);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, ok, now, tag, len, seq, node};
    do @(posedge clk); while (!s_tready);
  endtask

  // Holds the request side off until every outstanding response has been seen.
  task automatic pause_sender();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    pause_sender();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ATTEMPT_LIMIT) begin
      cfg_attempt_limit = (value[7:0] == 8'd0) ? 8'd1 : value[7:0];
    end else begin
      cfg_retry_timeout = value[30:0];
    end
    register_writes++;
  endtask

  task automatic configure(input logic [31:0] attempts, input logic [31:0] timeout);
    write_register(REG_ATTEMPT_LIMIT, attempts);
    write_register(REG_RETRY_TIMEOUT, timeout);
  endtask

  task automatic run_random_traffic(input int count, input int step_max);
    logic [2:0]  kind;
    logic [7:0]  node;
    logic [7:0]  seq;
    logic [7:0]  len;
    logic [15:0] tag;
    logic        ok;
    int          pick;
    int          slot;
    for (int n = 0; n < count; n++) begin
      clock_ms = clock_ms + $urandom_range(0, step_max);
      pick = $urandom_range(0, 99);
      node = 8'($urandom_range(0, 3));
      seq  = 8'($urandom_range(0, 7));
      len  = 8'($urandom_range(0, MAX_PAYLOAD));
      tag  = 16'($urandom_range(0, 65535));
      ok   = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        node = 8'($urandom_range(0, 255));
        seq  = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 11) == 0) len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
      if (pick < 34) kind = REQ_ENQUEUE;
      else if (pick < 64) kind = REQ_POLL;
      else if (pick < 80) kind = REQ_ACK;
      else if (pick < 92) kind = REQ_CANCEL;
      else if (pick < 95) kind = REQ_CLEAR;
      else kind = 3'($urandom_range(REQ_FIRST_UNKNOWN, REQ_LAST_UNKNOWN));
      // Most acknowledges and cancels name a frame that is really waiting.
      if ((kind == REQ_ACK || kind == REQ_CANCEL) && $urandom_range(0, 3) != 0) begin
        slot = $urandom_range(0, SLOTS - 1);
        if (tbl_valid[slot]) begin
          node = tbl_node[slot];
          seq  = tbl_seq[slot];
        end
      end
      send_request(kind, node, seq, len, tag, clock_ms, ok);
    end
  endtask

  task automatic test_directed_requests();
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd0, 1'b0);
    send_request(REQ_ENQUEUE, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd0, 1'b0);
    send_request(REQ_ENQUEUE, 8'hFF, 8'hFF, 8'(MAX_PAYLOAD), 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(REQ_ENQUEUE, 8'hFF, 8'hFF, 8'd1, 16'h1234, 32'd5, 1'b0);
    send_request(REQ_ENQUEUE, 8'd3, 8'd3, 8'(MAX_PAYLOAD + 1), 16'h0001, 32'd5, 1'b0);
    send_request(REQ_ENQUEUE, 8'd4, 8'd4, 8'hFF, 16'h0002, 32'd5, 1'b0);
    for (logic [3:0] k = {1'b0, REQ_FIRST_UNKNOWN}; k <= {1'b0, REQ_LAST_UNKNOWN}; k++) begin
      send_request(k[2:0], 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    end
    // The second frame's deadline is one behind zero, so it is due too.
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd0, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd0, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd500, 1'b0);
    send_request(REQ_ACK, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd600, 1'b1);
    send_request(REQ_ACK, 8'hFF, 8'hFF, 8'd0, 16'h0000, 32'd600, 1'b0);
    send_request(REQ_ACK, 8'd9, 8'd9, 8'd0, 16'h0000, 32'd600, 1'b0);
    send_request(REQ_ACK, 8'd9, 8'd9, 8'd0, 16'h0000, 32'd600, 1'b1);
    send_request(REQ_CANCEL, 8'd9, 8'd9, 8'd0, 16'h0000, 32'd600, 1'b0);
    for (int i = 1; i <= SLOTS + 1; i++) begin
      send_request(REQ_ENQUEUE, i[7:0], 8'h80, 8'd10, 16'hA000 + i[15:0], 32'd700, 1'b0);
    end
    send_request(REQ_ENQUEUE, 8'd1, 8'h80, 8'd10, 16'hBEEF, 32'd700, 1'b0);
    send_request(REQ_CANCEL, 8'd4, 8'h80, 8'd0, 16'h0000, 32'd700, 1'b0);
    send_request(REQ_CLEAR, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd700, 1'b0);
  endtask

  task automatic test_attempt_limits();
    // A zero limit counts as one transmission.
    configure(32'hFFFF_FF00, 32'd0);
    send_request(REQ_ENQUEUE, 8'd7, 8'd7, 8'd20, 16'h7777, 32'd100, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd100, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd100, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd100, 1'b0);
    // Longest timeout: deadlines sit half the counter away.
    configure(32'd255, 32'hFFFF_FFFF);
    send_request(REQ_ENQUEUE, 8'd1, 8'd2, 8'd0, 16'h5A5A, 32'd0, 1'b1);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd0, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'h7FFF_FFFE, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'h7FFF_FFFF, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'h7FFF_FFFF, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'h8000_0000, 1'b0);
    send_request(REQ_POLL, 8'd0, 8'd0, 8'd0, 16'h0000, 32'hFFFF_FFFE, 1'b0);
    send_request(REQ_CLEAR, 8'd0, 8'd0, 8'd0, 16'h0000, 32'd0, 1'b0);
  endtask

  task automatic test_random_settings();
    configure(32'd2, 32'd40);
    clock_ms = $urandom;
    run_random_traffic(150, 25);
    configure(32'd5, 32'd300);
    clock_ms = 32'hFFFF_F000;
    run_random_traffic(130, 120);
    configure(32'd1, 32'd0);
    run_random_traffic(70, 3);
    configure(32'd255, 32'd5);
    run_random_traffic(70, 10);
  endtask

  task automatic test_backpressure();
    configure(32'd3, 32'd16);
    sink_hold = 1'b1;
    while (!sink_holding) @(posedge clk);
    // The block keeps one response parked and must stall further requests.
    run_random_traffic(24, 10);
    pause_sender();
  endtask

  task automatic test_steady_stream();
    configure(32'd3, 32'd1000);
    calm = 1'b1;
    run_random_traffic(100, 400);
  endtask

  initial begin : stimulus
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i]    = 1'b0;
      tbl_node[i]     = '0;
      tbl_seq[i]      = '0;
      tbl_tag[i]      = '0;
      tbl_deadline[i] = '0;
      tbl_attempts[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_requests();
    test_attempt_limits();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    pause_sender();
    $display("Covered %0d requests and %0d checked responses (%0d exhausted, %0d full)",
             requests_accepted, responses_checked, exhausted_seen, full_seen);
    $display("over %0d register writes, with a long result stall and wrap-around deadlines.",
             register_writes);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
